/* design/qsmc_pkg.sv */
// ----------------------------------------------------------------------------
// qsmc_pkg: shared types and constants
// Field widths, operation codes and helpers for the sparse state block.
// ----------------------------------------------------------------------------
`default_nettype none
package qsmc_pkg;
    localparam int STORE_DEPTH = 64;
    localparam int IDX_W = $clog2(STORE_DEPTH);
    localparam int CNT_W = $clog2(STORE_DEPTH + 1);
    localparam logic [31:0] AMP_ONE = 32'h4000_0000;

    typedef enum logic [1:0] {
        OP_LOAD = 2'd0,
        OP_SET = 2'd1,
        OP_MBIT = 2'd2,
        OP_MREG = 2'd3
    } op_t;

    typedef struct packed {
        logic        start;
        logic [63:0] dividend;
        logic [31:0] divisor;
    } div_req_t;

    typedef struct packed {
        logic        done;
        logic [63:0] quotient;
    } div_rsp_t;

    function automatic logic [31:0] mag32(input logic [31:0] v);
        mag32 = v[31] ? (32'd0 - v) : v;
    endfunction

    function automatic logic [63:0] sat_add(input logic [63:0] a, input logic [63:0] b);
        logic [64:0] s;
        s = {1'b0, a} + {1'b0, b};
        sat_add = s[64] ? {64{1'b1}} : s[63:0];
    endfunction
endpackage
`default_nettype wire

/* design/qsmc_div.sv */
// ----------------------------------------------------------------------------
// qsmc_div: shared restoring divider
// Divides a 64-bit value by a 32-bit value, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module qsmc_div (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire qsmc_pkg::div_req_t req,
    output qsmc_pkg::div_rsp_t     rsp
);
    import qsmc_pkg::*;

    logic [63:0] quo_reg;
    logic [32:0] rem_reg;
    logic [31:0] dvs_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg;
    logic        done_reg;
    logic [32:0] trial;

    assign trial = {rem_reg[31:0], quo_reg[63]};
    assign rsp.done = done_reg;
    assign rsp.quotient = quo_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= 7'd64;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 7'd1;
                if (cnt_reg == 7'd1)
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            quo_reg <= req.dividend;
            rem_reg <= '0;
            dvs_reg <= req.divisor;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_reg <= trial - {1'b0, dvs_reg};
                quo_reg <= {quo_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial;
                quo_reg <= {quo_reg[62:0], 1'b0};
            end
        end
    end
endmodule
`default_nettype wire

/* design/quantum_state_measure_collapse.sv */
// ----------------------------------------------------------------------------
// quantum_state_measure_collapse: sparse state measurement
// Keeps basis states with Q2.30 complex amplitudes, measures and collapses them.
// ----------------------------------------------------------------------------
// Load and set write one entry. Bit measure walks the store up to three
// times through one shared 32x32 multiplier: the first two walks square
// the amplitude parts of the entries, a square root follows, and the
// rescale walk divides both amplitude parts of every kept entry in the
// shared serial divider; the store holds up to 64 entries.
// Register measure walks the store through the same multiplier. One beat
// is in work at a time; the result waits in the output register until taken.
`default_nettype none
module quantum_state_measure_collapse (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [1:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // op[1:0], entry_index[7:2], basis[71:8], amp_real[103:72],
    // amp_imag[135:104], target_bit[141:136], random_fraction[157:142]
    input  wire logic [159:0] s_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    // measured_value[63:0], status[64], state_count[71:65]
    output logic [71:0]       m_tdata
);
    import qsmc_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE  = 14'b00000000000001,
        S_DEC   = 14'b00000000000010,
        S_P1RD  = 14'b00000000000100,
        S_P1MUL = 14'b00000000001000,
        S_P2RD  = 14'b00000000010000,
        S_P2MUL = 14'b00000000100000,
        S_SQRT  = 14'b00000001000000,
        S_P3RD  = 14'b00000010000000,
        S_DIVRE = 14'b00000100000000,
        S_DIVIM = 14'b00001000000000,
        S_P3WR  = 14'b00010000000000,
        S_RRD   = 14'b00100000000000,
        S_RMUL  = 14'b01000000000000,
        S_OUT   = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    logic [63:0] bmem [STORE_DEPTH];
    logic [63:0] amem [STORE_DEPTH];
    logic [63:0] rd_b_reg;
    logic [63:0] rd_a_reg;
    logic [IDX_W-1:0] rd_addr;
    logic        we;
    logic [IDX_W-1:0] wr_addr;
    logic [63:0] wr_b, wr_a;
    logic        wb_en;

    logic [6:0]  qcnt_reg;
    logic [CNT_W-1:0] count_reg;
    logic [159:0] in_reg;
    logic [CNT_W-1:0] i_reg;
    logic [CNT_W-1:0] kept_reg;
    logic [63:0] acc_reg;
    logic [63:0] psq_reg;
    logic        res_reg;
    logic        half_reg;
    logic [63:0] val_reg;
    logic        stat_reg;
    logic [63:0] sq_x_reg, sq_r_reg, sq_bit_reg;
    logic [31:0] s_reg;
    logic [31:0] re_out_reg;
    logic        div_go_reg;
    logic        out_v_reg;

    logic [31:0] mul_a;
    logic [63:0] mul_p;
    div_req_t    dreq;
    div_rsp_t    drsp;

    op_t         op;
    logic [IDX_W-1:0] in_idx;
    logic [63:0] in_basis;
    logic [5:0]  in_tgt;
    logic [63:0] frac;
    logic        bit_set;
    logic [63:0] acc_sum;
    logic [63:0] qmask;
    logic [31:0] scaled;
    logic [31:0] dpart;
    logic [63:0] qsat;

    assign op       = op_t'(in_reg[1:0]);
    assign in_idx   = in_reg[7:2];
    assign in_basis = in_reg[71:8];
    assign in_tgt   = in_reg[141:136];
    assign frac     = {4'd0, in_reg[157:142], 44'd0};
    assign bit_set  = rd_b_reg[in_tgt];
    assign acc_sum  = sat_add(acc_reg, sat_add(psq_reg, mul_p));
    assign qmask    = (qcnt_reg >= 7'd64) ? {64{1'b1}}
                    : ((64'd1 << qcnt_reg[5:0]) - 64'd1);

    assign pready = 1'b1;
    assign prdata = {25'd0, qcnt_reg};
    assign s_tready = (state_reg == S_IDLE) && !out_v_reg;
    assign m_tvalid = out_v_reg;
    assign m_tdata  = {count_reg, stat_reg, val_reg};

    assign mul_a = mag32(half_reg ? rd_a_reg[63:32] : rd_a_reg[31:0]);
    assign mul_p = {32'd0, mul_a} * {32'd0, mul_a};

    qsmc_div u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (dreq),
        .rsp  (drsp)
    );

    assign dpart = (state_reg == S_DIVIM || state_reg == S_P3WR) ? rd_a_reg[63:32]
                 : rd_a_reg[31:0];
    assign dreq.start    = div_go_reg;
    assign dreq.dividend = {2'd0, mag32(dpart), 30'd0};
    assign dreq.divisor  = s_reg;
    assign qsat = drsp.quotient;
    always_comb
    begin
        if (dpart[31])
            scaled = (qsat >= 64'h8000_0000) ? 32'h8000_0000 : (32'd0 - qsat[31:0]);
        else
            scaled = (qsat > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : qsat[31:0];
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            bmem[wr_addr] <= wr_b;
            amem[wr_addr] <= wr_a;
        end
        rd_b_reg <= bmem[rd_addr];
        rd_a_reg <= amem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            qcnt_reg <= 7'd8;
        else if (psel && penable && pwrite && paddr == 2'd0)
            qcnt_reg <= pwdata[6:0];
    end

    always_comb
    begin
        state_next = state_reg;
        rd_addr = i_reg[IDX_W-1:0];
        we = 1'b0;
        wr_addr = kept_reg[IDX_W-1:0];
        wr_b = rd_b_reg;
        wr_a = rd_a_reg;
        wb_en = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid && s_tready)
                    state_next = S_DEC;
            end
            S_DEC:
            begin
                unique case (op)
                    OP_LOAD:
                    begin
                        we = 1'b1;
                        wr_addr = in_idx;
                        wr_b = in_basis;
                        wr_a = in_reg[135:72];
                        state_next = S_OUT;
                    end
                    OP_SET:
                    begin
                        we = 1'b1;
                        wr_addr = '0;
                        wr_b = in_basis;
                        wr_a = {32'd0, AMP_ONE};
                        state_next = S_OUT;
                    end
                    OP_MBIT: state_next = (count_reg == '0) ? S_P2RD : S_P1RD;
                    default: state_next = (count_reg == '0) ? S_OUT : S_RRD;
                endcase
            end
            S_P1RD: state_next = S_P1MUL;
            S_P1MUL:
            begin
                if (half_reg)
                    state_next = S_P1RD;
            end
            S_P2RD: state_next = (i_reg == count_reg) ? S_SQRT : S_P2MUL;
            S_P2MUL:
            begin
                if (half_reg)
                begin
                    state_next = S_P2RD;
                    if ((bit_set == res_reg) && rd_a_reg != 64'd0)
                        we = 1'b1;
                end
            end
            S_SQRT: ;
            S_P3RD: state_next = (i_reg == kept_reg) ? S_OUT : S_DIVRE;
            S_DIVRE:
            begin
                rd_addr = i_reg[IDX_W-1:0];
            end
            S_DIVIM: ;
            S_P3WR:
            begin
                we = 1'b1;
                wr_addr = i_reg[IDX_W-1:0];
                wr_b = rd_b_reg;
                wr_a = {scaled, re_out_reg};
                state_next = S_P3RD;
            end
            S_RRD: state_next = S_RMUL;
            S_RMUL: ;
            S_OUT:
            begin
                if (!out_v_reg)
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
        if (state_reg == S_P1MUL && half_reg)
        begin
            if (bit_set && sat_add(acc_reg, sat_add(psq_reg, mul_p)) > frac)
                state_next = S_P2RD;
            else if (i_reg + 1'b1 == count_reg)
                state_next = S_P2RD;
        end
        if (state_reg == S_RMUL && half_reg)
        begin
            if (rd_a_reg != 64'd0 && sat_add(acc_reg, sat_add(psq_reg, mul_p)) > frac)
            begin
                we = 1'b1;
                wr_addr = '0;
                wr_a = {32'd0, AMP_ONE};
                state_next = S_OUT;
            end
            else if (i_reg + 1'b1 == count_reg)
                state_next = S_OUT;
            else
                state_next = S_RRD;
        end
        if (state_reg == S_SQRT && sq_bit_reg == 64'd0)
            state_next = (kept_reg == '0 || acc_reg == 64'd0) ? S_OUT : S_P3RD;
        if (state_reg == S_DIVRE && drsp.done)
            state_next = S_DIVIM;
        if (state_reg == S_DIVIM && drsp.done)
            state_next = S_P3WR;
        if (state_reg == S_DIVRE || state_reg == S_DIVIM || state_reg == S_P3WR)
            rd_addr = i_reg[IDX_W-1:0];
        wb_en = we;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            out_v_reg <= 1'b0;
            count_reg <= '0;
            div_go_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            div_go_reg <= 1'b0;
            if (out_v_reg && m_tready)
                out_v_reg <= 1'b0;
            if (state_reg != S_OUT && state_next == S_OUT)
                out_v_reg <= 1'b1;
            if (state_reg == S_DEC && op == OP_LOAD)
                count_reg <= {1'b0, in_idx} + 1'b1;
            if (state_reg == S_DEC && op == OP_SET)
                count_reg <= CNT_W'(1);
            if (state_reg == S_P2RD && i_reg == count_reg)
                count_reg <= kept_reg;
            if (state_reg == S_RMUL && wb_en)
                count_reg <= CNT_W'(1);
            if ((state_reg == S_P3RD && i_reg != kept_reg)
                || (state_reg == S_DIVRE && drsp.done))
                div_go_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_tvalid && s_tready)
            in_reg <= s_tdata;
        unique case (state_reg)
            S_DEC:
            begin
                i_reg <= '0;
                kept_reg <= '0;
                acc_reg <= '0;
                psq_reg <= '0;
                res_reg <= 1'b0;
                half_reg <= 1'b0;
                val_reg <= '0;
                stat_reg <= (op == OP_MREG);
            end
            S_P1RD, S_P2RD, S_RRD:
            begin
                half_reg <= 1'b0;
                psq_reg <= '0;
                if (state_reg == S_P2RD && i_reg == count_reg)
                begin
                    sq_x_reg <= acc_reg;
                    sq_r_reg <= '0;
                    sq_bit_reg <= 64'h4000_0000_0000_0000;
                    val_reg <= {63'd0, res_reg};
                end
            end
            S_P1MUL:
            begin
                half_reg <= 1'b1;
                psq_reg <= mul_p;
                if (half_reg)
                begin
                    if (bit_set)
                    begin
                        acc_reg <= acc_sum;
                        if (sat_add(acc_reg, sat_add(psq_reg, mul_p)) > frac)
                            res_reg <= 1'b1;
                    end
                    i_reg <= i_reg + 1'b1;
                    if (state_next == S_P2RD)
                    begin
                        i_reg <= '0;
                        acc_reg <= '0;
                        if (bit_set && sat_add(acc_reg, sat_add(psq_reg, mul_p)) > frac)
                            res_reg <= 1'b1;
                    end
                end
            end
            S_P2MUL:
            begin
                half_reg <= 1'b1;
                psq_reg <= mul_p;
                if (half_reg)
                begin
                    i_reg <= i_reg + 1'b1;
                    if (wb_en)
                    begin
                        kept_reg <= kept_reg + 1'b1;
                        acc_reg <= sat_add(acc_reg, sat_add(psq_reg, mul_p));
                    end
                end
            end
            S_RMUL:
            begin
                half_reg <= 1'b1;
                psq_reg <= mul_p;
                if (half_reg)
                begin
                    i_reg <= i_reg + 1'b1;
                    if (rd_a_reg != 64'd0)
                        acc_reg <= sat_add(acc_reg, sat_add(psq_reg, mul_p));
                    if (wb_en)
                    begin
                        val_reg <= rd_b_reg & qmask;
                        stat_reg <= 1'b0;
                    end
                end
            end
            S_SQRT:
            begin
                i_reg <= '0;
                if (sq_bit_reg != 64'd0)
                begin
                    if (sq_x_reg >= sq_r_reg + sq_bit_reg)
                    begin
                        sq_x_reg <= sq_x_reg - (sq_r_reg + sq_bit_reg);
                        sq_r_reg <= (sq_r_reg >> 1) + sq_bit_reg;
                    end
                    else
                        sq_r_reg <= sq_r_reg >> 1;
                    sq_bit_reg <= sq_bit_reg >> 2;
                end
                else
                    s_reg <= sq_r_reg[31:0];
            end
            S_DIVRE:
            begin
                if (drsp.done)
                    re_out_reg <= scaled;
            end
            S_P3WR: i_reg <= i_reg + 1'b1;
            default: ;
        endcase
    end
endmodule
`default_nettype wire

/* design/qsmc_checker.sv */
// ----------------------------------------------------------------------------
// qsmc_checker: port-level checks
// Watches the stream and register ports of the measurement block.
// ----------------------------------------------------------------------------
`default_nettype none
module qsmc_checker (
    input wire logic         clk,
    input wire logic         rst_n,
    input wire logic         pready,
    input wire logic         s_tvalid,
    input wire logic         s_tready,
    input wire logic         m_tvalid,
    input wire logic         m_tready,
    input wire logic [71:0]  m_tdata
);
    a_stall_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");
    a_busy: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat accepted during work");
    a_no_in_out: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> !s_tready)
        else $error("input ready while result pending");
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[71:65] <= 7'd64)
        else $error("state count out of range");
    a_pready: assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");
endmodule

bind quantum_state_measure_collapse qsmc_checker u_qsmc_checker (
    .clk(clk), .rst_n(rst_n), .pready(pready), .s_tvalid(s_tvalid),
    .s_tready(s_tready), .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
`default_nettype wire
